// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property templates for the sine/cosine interpolator checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: rtl/tsci_pkg.sv
// ----------------------------------------------------------------------------
// tsci_pkg
// Formats and fixed-point constants of the table sine/cosine interpolator.
// ----------------------------------------------------------------------------
package tsci_pkg;

	localparam int ANGLE_W = 32;   // Q6.26 angle
	localparam int TRIG_W  = 32;   // Q2.30 results
	localparam int FRAC_W  = 16;   // fraction bits of the table position
	localparam int REM_W   = 28;   // divider remainder, holds values below pi
	localparam int T_W     = 27;   // folded angle, at most pi/2

	// Angles in Q6.26, rounded to nearest
	localparam logic [REM_W:0] HALF_PI_Q26       = 29'd105414357;
	localparam logic [REM_W:0] PI_Q26            = 29'd210828714;
	localparam logic [REM_W:0] THREE_HALF_PI_Q26 = 29'd316243071;
	localparam logic [REM_W:0] TWO_PI_Q26        = 29'd421657428;

	// pi/2 in unsigned Q60, used when the table is built
	localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
	localparam int SERIES_TERMS = 12;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [TRIG_W-1:0]  trig_t;

endpackage

// File: rtl/tsci_rom.sv
// ----------------------------------------------------------------------------
// tsci_rom
// Guarded quarter-wave sine table with a registered read port.
// ----------------------------------------------------------------------------
module tsci_rom #(
	parameter int TABLE_STEPS = 128
) (
	input  logic                              clk,
	input  logic [$clog2(TABLE_STEPS+3)-1:0]  addr,
	output tsci_pkg::trig_t                   data
);
	import tsci_pkg::*;

	typedef logic signed [TRIG_W-1:0] rom_t [0:TABLE_STEPS+2];

	localparam logic [63:0] STEPS_64 = 64'(TABLE_STEPS);
	localparam logic [63:0] SER_DIV [1:SERIES_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
	};

	// Unsigned Q60 product, truncated to 64 bits
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] prod;
		prod = {64'h0, a} * {64'h0, b};
		return prod[123:60];
	endfunction

	// Taylor series of sin(x), x in [0, pi/2], Q60
	function automatic logic [63:0] sine_q60(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		x2   = mul_q60(x, x);
		term = x;
		sum  = x;
		for (int n = 1; n <= SERIES_TERMS; n++) begin
			term = mul_q60(term, x2) / SER_DIV[n];
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum;
	endfunction

	function automatic rom_t build_rom();
		rom_t        tbl;
		logic [63:0] step;
		logic [63:0] rest;
		logic [63:0] x;
		logic [63:0] s;
		step = HALF_PI_Q60 / STEPS_64;
		rest = HALF_PI_Q60 % STEPS_64;
		for (int k = 0; k <= TABLE_STEPS; k++) begin
			x = step * 64'(k) + (rest * 64'(k)) / STEPS_64;
			s = (sine_q60(x) + 64'h2000_0000) >> 30;
			tbl[k+1] = TRIG_W'(s);
		end
		// guards: odd extension below zero, mirror past pi/2
		tbl[0]             = -tbl[2];
		tbl[TABLE_STEPS+2] = tbl[TABLE_STEPS];
		return tbl;
	endfunction

	localparam rom_t ROM_TBL = build_rom();

	always_ff @(posedge clk) begin
		data <= ROM_TBL[addr];
	end

endmodule

// File: rtl/tsci_div.sv
// ----------------------------------------------------------------------------
// tsci_div
// Division by the constant pi (Q6.26) through a reciprocal multiply and one
// correction step, on one shared multiplier (phases: estimate, quotient, back, fix).
// ----------------------------------------------------------------------------
module tsci_div #(
	parameter int TABLE_STEPS = 128,
	parameter int QW = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tsci_pkg::T_W-1:0]       t,
	input  logic [QW+tsci_pkg::REM_W-1:0] num,
	output logic                          done,
	output logic [QW-1:0]                 quo
);
	import tsci_pkg::*;

	localparam int NW   = QW + REM_W;
	localparam int RW   = REM_W + 1;
	localparam int MA_W = (QW > T_W) ? QW : T_W;
	localparam int PW   = MA_W + RW;

	// floor(2 * TABLE_STEPS * 2^(FRAC_W + T_W) / pi); the estimate is low by at most one
	localparam logic [RW-1:0] RECIP =
		RW'((64'(2 * TABLE_STEPS) << (FRAC_W + T_W)) / 64'(PI_Q26));

	localparam logic [2:0] P_IDLE = 3'd0;
	localparam logic [2:0] P_EST  = 3'd1;
	localparam logic [2:0] P_QUO  = 3'd2;
	localparam logic [2:0] P_BACK = 3'd3;
	localparam logic [2:0] P_FIX  = 3'd4;

	logic [2:0]      ph_q;
	logic            done_q;
	logic [PW-1:0]   prod_q;
	logic [QW-1:0]   quo_q;
	logic [NW-1:0]   back_q;

	logic [MA_W-1:0] mul_a;
	logic [RW-1:0]   mul_b;
	logic [PW-1:0]   mul_p;
	logic [NW-1:0]   rem_w;

	// t and num are held by the caller until done
	assign mul_a = (ph_q == P_EST) ? MA_W'(t) : MA_W'(quo_q);
	assign mul_b = (ph_q == P_EST) ? RECIP : PI_Q26;
	assign mul_p = PW'(mul_a) * PW'(mul_b);
	assign rem_w = num - back_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= P_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (ph_q)
				P_IDLE: begin
					if (start) begin
						ph_q <= P_EST;
					end
				end
				P_EST:  ph_q <= P_QUO;
				P_QUO:  ph_q <= P_BACK;
				P_BACK: ph_q <= P_FIX;
				P_FIX: begin
					ph_q   <= P_IDLE;
					done_q <= 1'b1;
				end
				default: ph_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ph_q)
			P_EST:  prod_q <= mul_p;
			P_QUO:  quo_q  <= prod_q[T_W+QW-1:T_W];
			P_BACK: back_q <= mul_p[NW-1:0];
			P_FIX: begin
				// remainder at or above pi: advance the quotient by one
				if (rem_w >= NW'(PI_Q26)) begin
					quo_q <= quo_q + QW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: rtl/table_sine_cosine_interp.sv
// ----------------------------------------------------------------------------
// table_sine_cosine_interp
// Sine and cosine of a Q6.26 angle by interpolation in a quarter-wave table.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with an angle (radians, signed Q6.26) while busy is low; the
//   transaction is taken at that clock edge and busy rises in the next cycle.
//   The block then works alone on that angle: it wraps it into [0, 2*pi)
//   with one add of +/-2*pi per cycle (up to 6), folds it into the first
//   quadrant, scales it to a table position, divides by pi with a reciprocal
//   multiply and one correction step, reads four table samples one
//   per cycle, then interpolates sine and cosine through one shared
//   subtract/multiply/add path.
//   The table reads are followed by two four-step interpolation passes.
//   A new angle is taken from the done cycle on, not while one is in work.
//   done is high for exactly one cycle with sine and cosine (Q2.30); the
//   receiver cannot stall, so it must take the transaction in that cycle.
//   Reset clears the sequencer to idle; an angle in work is dropped and
//   none is pending.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module table_sine_cosine_interp #(
	parameter int TABLE_STEPS = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tsci_pkg::angle_t  angle,
	output logic              busy,
	output logic              done,
	output tsci_pkg::trig_t   sine,
	output tsci_pkg::trig_t   cosine
);
	import tsci_pkg::*;

	localparam int IW     = $clog2(TABLE_STEPS + 1);
	localparam int QW     = IW + FRAC_W;
	localparam int NW     = QW + REM_W;
	localparam int MW     = T_W + $clog2(2 * TABLE_STEPS + 1);
	localparam int AW     = $clog2(TABLE_STEPS + 3);
	localparam int ACC_W  = ANGLE_W + 1;
	localparam int DIFF_W = TRIG_W + 1;
	localparam int PROD_W = DIFF_W + FRAC_W + 1;
	localparam int SUM_W  = PROD_W + 1;

	localparam logic signed [ACC_W-1:0] TWO_PI_S = $signed(ACC_W'(TWO_PI_Q26));

	// sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_WRAP     = 4'd1;
	localparam logic [3:0] S_FOLD     = 4'd2;
	localparam logic [3:0] S_SCALE    = 4'd3;
	localparam logic [3:0] S_DIV_GO   = 4'd4;
	localparam logic [3:0] S_DIV_WAIT = 4'd5;
	localparam logic [3:0] S_READ     = 4'd6;
	localparam logic [3:0] S_DIFF     = 4'd7;
	localparam logic [3:0] S_MULT     = 4'd8;
	localparam logic [3:0] S_SUM      = 4'd9;
	localparam logic [3:0] S_SIGN     = 4'd10;

	logic [3:0] state_q;
	logic [2:0] ph_q;       // table read phase, 0..4
	logic       chan_q;     // 0: sine pass, 1: cosine pass
	logic       done_q;

	logic signed [ACC_W-1:0]  acc_q;
	logic [T_W-1:0]           t_q;
	logic                     neg_s_q;
	logic                     neg_c_q;
	logic [NW-1:0]            num_q;
	logic [IW-1:0]            idx_q;
	logic [FRAC_W-1:0]        frac_q;
	trig_t                    samp_q [0:3];
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [PROD_W-1:0] prod_q;
	trig_t                    val_q;
	trig_t                    sine_q;
	trig_t                    cosine_q;

	logic              accept;
	logic              wrap_neg;
	logic              wrap_hi;
	logic [REM_W:0]    r_w;
	logic [REM_W:0]    minu;
	logic [REM_W:0]    subt;
	logic [REM_W:0]    t_w;
	logic              q1;
	logic              q2;
	logic              q3;
	logic              div_start;
	logic              div_done;
	logic [QW-1:0]     div_quo;
	logic [IW-1:0]     idx_raw;
	logic [AW-1:0]     rom_addr;
	trig_t             rom_data;
	trig_t             base;
	trig_t             nxt;
	logic              neg;
	logic signed [SUM_W-1:0] sum_w;

	assign accept    = start && !busy;
	assign div_start = (state_q == S_DIV_GO);

	// wrap: add 2*pi while negative, subtract while at or above 2*pi
	assign wrap_neg = acc_q[ACC_W-1];
	assign wrap_hi  = (acc_q >= TWO_PI_S);

	// fold into [0, pi/2] with one subtract, operands picked by quadrant
	assign r_w = acc_q[REM_W:0];
	assign q1  = (r_w >= HALF_PI_Q26) && (r_w < PI_Q26);
	assign q2  = (r_w >= PI_Q26) && (r_w < THREE_HALF_PI_Q26);
	assign q3  = (r_w >= THREE_HALF_PI_Q26);

	always_comb begin
		priority if (q1) begin
			minu = PI_Q26;
			subt = r_w;
		end else if (q2) begin
			minu = r_w;
			subt = PI_Q26;
		end else if (q3) begin
			minu = TWO_PI_Q26;
			subt = r_w;
		end else begin
			minu = r_w;
			subt = '0;
		end
	end
	assign t_w = minu - subt;

	// t_q and num_q hold while the divider runs
	tsci_div #(
		.TABLE_STEPS(TABLE_STEPS),
		.QW(QW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.t      (t_q),
		.num    (num_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign idx_raw = div_quo[QW-1:FRAC_W];

	// read order: sine base, sine next, cosine base, cosine next
	always_comb begin
		unique case (ph_q[1:0])
			2'd0: rom_addr = AW'(idx_q) + AW'(1);
			2'd1: rom_addr = AW'(idx_q) + AW'(2);
			2'd2: rom_addr = AW'(TABLE_STEPS + 1) - AW'(idx_q);
			default: rom_addr = AW'(TABLE_STEPS) - AW'(idx_q);
		endcase
	end

	tsci_rom #(
		.TABLE_STEPS(TABLE_STEPS)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	// interpolation operands of the current pass
	assign base = chan_q ? samp_q[2] : samp_q[0];
	assign nxt  = chan_q ? samp_q[3] : samp_q[1];
	assign neg  = chan_q ? neg_c_q : neg_s_q;

	// a*65536 + (b-a)*frac + half, floored by the later shift
	assign sum_w = $signed({{(SUM_W-TRIG_W-FRAC_W){base[TRIG_W-1]}}, base, FRAC_W'(0)})
		+ $signed({prod_q[PROD_W-1], prod_q})
		+ $signed(SUM_W'(32768));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= '0;
			chan_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_WRAP;
					end
				end
				S_WRAP: begin
					if (!wrap_neg && !wrap_hi) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD:   state_q <= S_SCALE;
				S_SCALE:  state_q <= S_DIV_GO;
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_done) begin
						state_q <= S_READ;
						ph_q    <= '0;
					end
				end
				S_READ: begin
					ph_q <= ph_q + 3'd1;
					if (ph_q == 3'd4) begin
						state_q <= S_DIFF;
						chan_q  <= 1'b0;
					end
				end
				S_DIFF: state_q <= S_MULT;
				S_MULT: state_q <= S_SUM;
				S_SUM:  state_q <= S_SIGN;
				S_SIGN: begin
					if (!chan_q) begin
						// advance to the cosine pass
						chan_q  <= 1'b1;
						state_q <= S_DIFF;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, loaded under the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					acc_q <= ACC_W'(angle);
				end
			end
			S_WRAP: begin
				if (wrap_neg) begin
					acc_q <= acc_q + TWO_PI_S;
				end else if (wrap_hi) begin
					acc_q <= acc_q - TWO_PI_S;
				end
			end
			S_FOLD: begin
				t_q     <= t_w[T_W-1:0];
				neg_s_q <= q2 || q3;
				neg_c_q <= q1 || q2;
			end
			S_SCALE: begin
				num_q <= NW'({MW'(t_q) * MW'(2 * TABLE_STEPS), FRAC_W'(0)});
			end
			S_DIV_WAIT: begin
				if (div_done) begin
					// saturate past the quarter wave
					if (idx_raw >= IW'(TABLE_STEPS)) begin
						idx_q  <= IW'(TABLE_STEPS);
						frac_q <= '0;
					end else begin
						idx_q  <= idx_raw;
						frac_q <= div_quo[FRAC_W-1:0];
					end
				end
			end
			S_READ: begin
				if (ph_q != 3'd0) begin
					samp_q[2'(ph_q - 3'd1)] <= rom_data;
				end
			end
			S_DIFF: begin
				diff_q <= {nxt[TRIG_W-1], nxt} - {base[TRIG_W-1], base};
			end
			S_MULT: begin
				prod_q <= PROD_W'(diff_q) * PROD_W'($signed({1'b0, frac_q}));
			end
			S_SUM: begin
				val_q <= sum_w[TRIG_W+FRAC_W-1:FRAC_W];
			end
			S_SIGN: begin
				if (chan_q) begin
					cosine_q <= neg ? -val_q : val_q;
				end else begin
					sine_q <= neg ? -val_q : val_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign sine   = sine_q;
	assign cosine = cosine_q;

	// checks
	`CHK_NEXT(a_accept_busy, clk, arst_n, accept, busy)
	`CHK_IMPL(a_done_idle, clk, arst_n, done, !busy)
	`CHK_NEXT(a_done_single, clk, arst_n, done, !done)
	`CHK_IMPL(a_wrap_range, clk, arst_n, state_q == S_FOLD, !acc_q[ACC_W-1] && acc_q < TWO_PI_S)

endmodule
